FILE: rtl/core/fcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_pkg: shared types and constants of the frame change detector
// Register indexes, widths, the divide-by-20 reciprocal and stage structs.
// ----------------------------------------------------------------------------
package fcd_pkg;

  localparam int unsigned SIZE_BITS = 24;
  localparam int unsigned QUOT_BITS = SIZE_BITS - 4;
  localparam int unsigned CMP_BITS  = (SIZE_BITS > 24) ? SIZE_BITS : 24;
  localparam int unsigned PROD_BITS = SIZE_BITS - 2 + 32;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CfgEnable       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CfgSampleStride = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CfgSizeFloor    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CfgBitThreshold = CFG_IDX_W'(3);

  localparam logic        RstEnable       = 1'b0;
  localparam logic [12:0] RstSampleStride = 13'd64;
  localparam logic [23:0] RstSizeFloor    = 24'd800;
  localparam logic [5:0]  RstBitThreshold = 6'd6;

  localparam logic [12:0] StrideMax = 13'd4096;

  // ceil(2^34 / 5): (x / 4) * Recip5 >> 34 equals x / 20 for any x below 2^32
  localparam logic [31:0] Recip5 = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift = 34;

  typedef struct packed {
    logic        enable;
    logic [12:0] sample_stride;
    logic [23:0] size_floor;
    logic [5:0]  bit_threshold;
  } cfg_t;

  typedef struct packed {
    logic                 bypass;
    logic [SIZE_BITS-1:0] size;
    logic [31:0]          hash;
  } frame_t;

  typedef struct packed {
    logic                 bypass;
    logic [SIZE_BITS-1:0] size;
    logic [31:0]          hash;
    logic [QUOT_BITS-1:0] quot;
  } judge_t;

endpackage
`default_nettype wire

FILE: rtl/core/fcd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_in_if: frame byte channel
// One byte of the compressed frame per item, with a final-byte flag.
// ----------------------------------------------------------------------------
interface fcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/fcd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_out_if: frame result channel
// One item per finished frame: change flag, size and fingerprint.
// ----------------------------------------------------------------------------
interface fcd_out_if;
  logic        valid;
  logic        ready;
  logic        changed;
  logic [23:0] frame_len;
  logic [31:0] fingerprint;

  modport source (output valid, output changed, output frame_len, output fingerprint,
                  input ready);
  modport sink (input valid, input changed, input frame_len, input fingerprint,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/core/fcd_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_cfg_if: configuration write channel
// Register index and write data, taken on valid and ready.
// ----------------------------------------------------------------------------
interface fcd_cfg_if;
  import fcd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/fcd_accum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_accum: frame length counter and sampled XOR fingerprint
// Steps the count, stride phase and hash per item; presents the finished frame.
// ----------------------------------------------------------------------------
module fcd_accum (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      frame_byte_i,
  input  logic            last_byte_i,
  input  fcd_pkg::cfg_t   cfg_i,
  output fcd_pkg::frame_t frame_o
);
  import fcd_pkg::*;

  logic [SIZE_BITS-1:0] idx_q, idx_d, idx_step;
  logic [11:0]          phase_q, phase_d, phase_step;
  logic [31:0]          hash_q, hash_d, hash_step;
  logic [12:0]          stride;
  logic [12:0]          phase_inc;
  logic [31:0]          shifted;

  always_comb begin
    if (cfg_i.sample_stride == 13'd0) begin
      stride = 13'd1;
    end else if (cfg_i.sample_stride > StrideMax) begin
      stride = StrideMax;
    end else begin
      stride = cfg_i.sample_stride;
    end
  end

  always_comb begin
    case (idx_q[1:0])
      2'd0:    shifted = {24'd0, frame_byte_i};
      2'd1:    shifted = {16'd0, frame_byte_i, 8'd0};
      2'd2:    shifted = {8'd0, frame_byte_i, 16'd0};
      2'd3:    shifted = {frame_byte_i, 24'd0};
      default: shifted = 32'd0;
    endcase
  end

  assign phase_inc  = {1'b0, phase_q} + 13'd1;
  assign phase_step = (phase_inc >= stride) ? 12'd0 : phase_inc[11:0];
  assign hash_step  = (phase_q == 12'd0) ? (hash_q ^ shifted) : hash_q;
  assign idx_step   = (&idx_q) ? idx_q : idx_q + SIZE_BITS'(1);

  always_comb begin
    idx_d   = idx_q;
    phase_d = phase_q;
    hash_d  = hash_q;
    if (fire_i && cfg_i.enable) begin
      if (last_byte_i) begin
        idx_d   = '0;
        phase_d = '0;
        hash_d  = '0;
      end else begin
        idx_d   = idx_step;
        phase_d = phase_step;
        hash_d  = hash_step;
      end
    end
  end

  always_comb begin
    frame_o.bypass = !cfg_i.enable;
    frame_o.size   = cfg_i.enable ? idx_step : '0;
    frame_o.hash   = cfg_i.enable ? hash_step : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      phase_q <= '0;
      hash_q  <= '0;
    end else begin
      idx_q   <= idx_d;
      phase_q <= phase_d;
      hash_q  <= hash_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/fcd_judge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcd_judge: change decision against the previous frame
// Compares size and fingerprint, then keeps this frame as the reference.
// ----------------------------------------------------------------------------
module fcd_judge (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  fcd_pkg::judge_t frame_i,
  input  fcd_pkg::cfg_t   cfg_i,
  output logic            changed_o
);
  import fcd_pkg::*;

  logic [SIZE_BITS-1:0] prev_size_q;
  logic [QUOT_BITS-1:0] prev_quot_q;
  logic [31:0]          prev_hash_q;
  logic                 have_prev_q;
  logic [CMP_BITS-1:0]  diff;
  logic [CMP_BITS-1:0]  thr;
  logic [CMP_BITS-1:0]  quot_ext;
  logic [CMP_BITS-1:0]  floor_ext;
  logic [5:0]           ones;

  assign diff = (frame_i.size > prev_size_q) ? CMP_BITS'(frame_i.size - prev_size_q)
                                             : CMP_BITS'(prev_size_q - frame_i.size);
  assign quot_ext  = CMP_BITS'(prev_quot_q);
  assign floor_ext = CMP_BITS'(cfg_i.size_floor);
  assign thr       = (quot_ext < floor_ext) ? floor_ext : quot_ext;
  assign ones      = 6'($countones(frame_i.hash ^ prev_hash_q));

  assign changed_o = !frame_i.bypass &&
                     (!have_prev_q || (diff > thr) || (ones > cfg_i.bit_threshold));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_size_q <= '0;
      prev_quot_q <= '0;
      prev_hash_q <= '0;
      have_prev_q <= 1'b0;
    end else if (fire_i && !frame_i.bypass) begin
      prev_size_q <= frame_i.size;
      prev_quot_q <= frame_i.quot;
      prev_hash_q <= frame_i.hash;
      have_prev_q <= 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/frame_change_detector_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_change_detector_top: camera frame change detector
// Counts frame bytes, folds sampled bytes into a fingerprint, flags changes.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  in_i      in   valid/ready   frame_byte[7:0], last_byte
//  out_o     out  valid/ready   changed, frame_len[23:0], fingerprint[31:0]
//  cfg_i     in   valid/ready   index[3:0], data[31:0]; ready always high
//
//  One byte item per cycle while no stall on out_o backs up the stages; the
//  counter/hash update sets this. A result leaves through registered stages
//  after its final byte: accumulate, divide by 20 (one multiply), compare and popcount.
//  Reset clears the counters, the stored reference and all stage valids.
//  Stages fill bubbles; a stall on out_o backs up only once all three are full.
// ----------------------------------------------------------------------------
module frame_change_detector_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  fcd_in_if.sink    in_i,
  fcd_out_if.source out_o,
  fcd_cfg_if.sink   cfg_i
);
  import fcd_pkg::*;

  cfg_t   cfg_q;
  frame_t frame_c;
  frame_t f1_q;
  judge_t f2_q;
  logic   v1_q, v2_q, vo_q;
  logic   adv1, adv2, advo;
  logic   in_fire;
  logic   changed_c;
  logic   chg_q;
  logic [23:0] size_q;
  logic [31:0] hash_q;
  logic [PROD_BITS-1:0] prod;

  assign advo    = !vo_q || out_o.ready;
  assign adv2    = !v2_q || advo;
  assign adv1    = !v1_q || adv2;
  assign in_i.ready = adv1;
  assign in_fire = in_i.valid && adv1;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable        <= RstEnable;
      cfg_q.sample_stride <= RstSampleStride;
      cfg_q.size_floor    <= RstSizeFloor;
      cfg_q.bit_threshold <= RstBitThreshold;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgEnable:       cfg_q.enable        <= cfg_i.data[0];
        CfgSampleStride: cfg_q.sample_stride <= cfg_i.data[12:0];
        CfgSizeFloor:    cfg_q.size_floor    <= cfg_i.data[23:0];
        CfgBitThreshold: cfg_q.bit_threshold <= cfg_i.data[5:0];
        default: ;
      endcase
    end
  end

  fcd_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (in_fire),
    .frame_byte_i (in_i.frame_byte),
    .last_byte_i  (in_i.last_byte),
    .cfg_i        (cfg_q),
    .frame_o      (frame_c)
  );

  assign prod = PROD_BITS'(f1_q.size[SIZE_BITS-1:2]) * PROD_BITS'(Recip5);

  fcd_judge u_judge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (v2_q && advo),
    .frame_i   (f2_q),
    .cfg_i     (cfg_q),
    .changed_o (changed_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_fire && in_i.last_byte;
      if (adv2) v2_q <= v1_q;
      if (advo) vo_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_fire && in_i.last_byte) begin
      f1_q <= frame_c;
    end
    if (adv2 && v1_q) begin
      f2_q.bypass <= f1_q.bypass;
      f2_q.size   <= f1_q.size;
      f2_q.hash   <= f1_q.hash;
      f2_q.quot   <= prod[PROD_BITS-1:RecipShift];
    end
    if (advo && v2_q) begin
      chg_q  <= changed_c;
      size_q <= 24'(f2_q.size);
      hash_q <= f2_q.hash;
    end
  end

  assign out_o.valid       = vo_q;
  assign out_o.changed     = chg_q;
  assign out_o.frame_len   = size_q;
  assign out_o.fingerprint = hash_q;

  a_mid_byte_no_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && !in_i.last_byte) |=> !v1_q)
    else $error("non-final byte produced a frame");

  a_last_byte_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.last_byte) |=> v1_q)
    else $error("final byte produced no frame");

  a_stage2_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !advo) |=> (v2_q && $stable(f2_q)))
    else $error("stalled frame lost in compare stage");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: frame change detector
// Streams camera frame bytes with random bursts and output stalls, predicts
// each frame result (size, fingerprint, change flag) and checks every field.
// ----------------------------------------------------------------------------
module testbench;
  import fcd_pkg::*;

  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned ItemTarget  = 2000;
  localparam logic [12:0] StrideCap   = 13'd4096;

  typedef struct packed {
    logic        changed;
    logic [23:0] size;
    logic [31:0] fp;
  } verdict_t;

  typedef enum int unsigned {RxAlways, RxCoin, RxCycle, RxMostly} rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fcd_in_if  in_if ();
  fcd_out_if out_if ();
  fcd_cfg_if cfg_if ();

  frame_change_detector_top u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic        m_enable = 1'b0;
  logic [12:0] m_stride = 13'd64;
  logic [23:0] m_floor  = 24'd800;
  logic [5:0]  m_thresh = 6'd6;

  logic [23:0] acc_len    = '0;
  logic [11:0] acc_phase  = '0;
  logic [31:0] acc_fp     = '0;
  logic [23:0] prev_len   = '0;
  logic [31:0] prev_fp    = '0;
  logic        prev_valid = 1'b0;

  verdict_t pending_verdicts[$];

  int fail_count       = 0;
  int bytes_sent       = 0;
  int verdicts_checked = 0;
  int changes_seen     = 0;
  int cfg_writes       = 0;
  int idle_cycles      = 0;

  bit       idle_en    = 1'b0;
  int       burst_left = 0;
  int       hold_left  = 0;
  rx_mode_e rx_mode    = RxAlways;

  logic [7:0] frame_buf[8192];
  logic [7:0] prev_buf[8192];
  int         prev_buf_len = 0;

  function automatic void predict_byte(input logic [7:0] b, input logic last);
    logic [12:0] stride;
    logic [12:0] next_phase;
    logic [23:0] diff;
    logic [23:0] limit;
    verdict_t    v;
    v = '0;
    if (!m_enable) begin
      if (last) pending_verdicts.push_back(v);
      return;
    end
    if (m_stride == 13'd0) stride = 13'd1;
    else if (m_stride > StrideCap) stride = StrideCap;
    else stride = m_stride;
    if (acc_phase == 12'd0) acc_fp = acc_fp ^ ({24'd0, b} << {acc_len[1:0], 3'b000});
    next_phase = {1'b0, acc_phase} + 13'd1;
    acc_phase = (next_phase >= stride) ? 12'd0 : next_phase[11:0];
    if (acc_len != '1) acc_len = acc_len + 24'd1;
    if (!last) return;
    v.size = acc_len;
    v.fp   = acc_fp;
    if (!prev_valid) begin
      v.changed = 1'b1;
    end else begin
      diff  = (acc_len > prev_len) ? acc_len - prev_len : prev_len - acc_len;
      limit = prev_len / 24'd20;
      if (limit < m_floor) limit = m_floor;
      v.changed = (diff > limit) || ($countones(acc_fp ^ prev_fp) > int'(m_thresh));
    end
    prev_len   = acc_len;
    prev_fp    = acc_fp;
    prev_valid = 1'b1;
    acc_len    = '0;
    acc_phase  = '0;
    acc_fp     = '0;
    pending_verdicts.push_back(v);
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CfgEnable:       m_enable = data[0];
      CfgSampleStride: m_stride = data[12:0];
      CfgSizeFloor:    m_floor  = data[23:0];
      CfgBitThreshold: m_thresh = data[5:0];
      default: ;
    endcase
  endfunction

  function automatic logic [12:0] pick_stride();
    case ($urandom_range(0, 7))
      0: return 13'd0;
      1: return StrideCap;
      2: return 13'h1FFF;
      3: return 13'($urandom_range(4095, 8191));
      4: return 13'd64;
      default: return 13'($urandom_range(1, 9));
    endcase
  endfunction

  function automatic logic [23:0] pick_floor();
    case ($urandom_range(0, 7))
      0: return 24'd0;
      1: return 24'd800;
      2: return 24'hFFFFFF;
      3: return 24'($urandom());
      default: return 24'($urandom_range(0, 40));
    endcase
  endfunction

  function automatic logic [5:0] pick_thresh();
    case ($urandom_range(0, 7))
      0: return 6'd0;
      1: return 6'd32;
      2: return 6'd33;
      3: return 6'd63;
      4: return 6'($urandom());
      default: return 6'($urandom_range(0, 8));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_en) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left--;
    end
    in_if.valid      <= 1'b1;
    in_if.frame_byte <= b;
    in_if.last_byte  <= last;
    do @(posedge clk_i); while (!in_if.ready);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame(input int len, input bit close);
    for (int i = 0; i < len; i++) send_byte(frame_buf[i], close && (i == len - 1));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    in_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    apply_reg(idx, data);
    cfg_writes++;
  endtask

  task automatic set_cfg(input logic en, input logic [12:0] stride,
                         input logic [23:0] size_min, input logic [5:0] thr);
    logic [31:0] noise;
    noise = $urandom();
    write_reg(CfgEnable, {noise[31:1], en});
    write_reg(CfgSampleStride, {noise[31:13], stride});
    write_reg(CfgSizeFloor, {noise[31:24], size_min});
    write_reg(CfgBitThreshold, {noise[31:6], thr});
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(int'(CfgBitThreshold) + 1, 15)), $urandom());
  endtask

  task automatic test_disabled_after_reset();
    frame_buf[0] = 8'h00;
    frame_buf[1] = 8'hFF;
    frame_buf[2] = 8'h3C;
    send_frame(3, 1'b1);
  endtask

  task automatic test_first_frame();
    set_cfg(1'b1, 13'd1, 24'd0, 6'd0);
    frame_buf[0] = 8'h00;
    frame_buf[1] = 8'hFF;
    frame_buf[2] = 8'h80;
    frame_buf[3] = 8'h01;
    send_frame(4, 1'b1);
    send_frame(4, 1'b1);
    frame_buf[0] = 8'hFF;
    send_frame(1, 1'b1);
  endtask

  task automatic test_thresholds();
    set_cfg(1'b1, 13'd1, 24'd3, 6'd32);
    for (int i = 0; i < 4; i++) frame_buf[i] = 8'hFF;
    send_frame(4, 1'b1);
    for (int i = 0; i < 4; i++) frame_buf[i] = 8'h00;
    send_frame(4, 1'b1);
    write_reg(CfgBitThreshold, 32'd33);
    for (int i = 0; i < 4; i++) frame_buf[i] = 8'hFF;
    send_frame(4, 1'b1);
  endtask

  task automatic test_stride_extremes();
    set_cfg(1'b1, 13'd0, 24'd0, 6'd6);
    frame_buf[0] = 8'h11;
    frame_buf[1] = 8'h22;
    send_frame(2, 1'b1);
    write_reg(CfgSampleStride, 32'h0000_1FFF);
    send_frame(2, 1'b1);
  endtask

  task automatic test_mid_frame_changes();
    set_cfg(1'b1, 13'd2, 24'd800, 6'd6);
    frame_buf[0] = 8'hA5;
    frame_buf[1] = 8'h5A;
    frame_buf[2] = 8'hC3;
    send_frame(3, 1'b0);
    write_reg(CfgSampleStride, 32'd1);
    send_frame(2, 1'b1);
    send_frame(1, 1'b0);
    write_reg(CfgEnable, 32'd0);
    send_frame(1, 1'b1);
    write_reg(CfgEnable, 32'd1);
    send_frame(1, 1'b1);
  endtask

  task automatic test_output_stall();
    idle_en   = 1'b0;
    rx_mode   = RxAlways;
    hold_left = HoldCycles;
    for (int i = 0; i < 60; i++) send_byte(8'($urandom()), $urandom_range(0, 1) == 1);
  endtask

  task automatic test_random_frames();
    int stop_at;
    int frames;
    int nframes;
    int len;
    int pos;
    bit close;
    stop_at    = bytes_sent + ItemTarget;
    frames     = 0;
    while (bytes_sent < stop_at || frames < 40) begin
      set_cfg($urandom_range(0, 6) != 0, pick_stride(), pick_floor(), pick_thresh());
      idle_en = $urandom_range(0, 3) != 0;
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      nframes = $urandom_range(3, 12);
      for (int f = 0; f < nframes; f++) begin
        if (prev_buf_len > 0 && $urandom_range(0, 9) < 4) begin
          len = prev_buf_len - 2 + int'($urandom_range(0, 4));
          if (len < 1) len = 1;
          for (int i = 0; i < len; i++)
            frame_buf[i] = (i < prev_buf_len) ? prev_buf[i] : 8'($urandom());
          repeat ($urandom_range(0, 2)) begin
            pos = $urandom_range(0, len - 1);
            frame_buf[pos] = frame_buf[pos] ^ (8'd1 << $urandom_range(0, 7));
          end
        end else begin
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 40);
          for (int i = 0; i < len; i++) frame_buf[i] = 8'($urandom());
        end
        close = $urandom_range(0, 19) != 0;
        send_frame(len, close);
        if (close) begin
          for (int i = 0; i < len; i++) prev_buf[i] = frame_buf[i];
          prev_buf_len = len;
          frames++;
        end
      end
    end
  endtask

  initial begin
    int cyc;
    cyc = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RxAlways: out_if.ready <= 1'b1;
          RxCoin:   out_if.ready <= 1'($urandom_range(0, 1));
          RxCycle:  out_if.ready <= (cyc % 7) < 4;
          default:  out_if.ready <= $urandom_range(0, 9) != 0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected frame result: changed %0d, frame_len %0d, fingerprint %h",
               out_if.changed, out_if.frame_len, out_if.fingerprint);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        verdicts_checked++;
        if (want.changed) changes_seen++;
        if (out_if.changed !== want.changed) begin
          $error("changed: expected %0d, actual %0d", want.changed, out_if.changed);
          fail_count++;
        end
        if (out_if.frame_len !== want.size) begin
          $error("frame_len: expected %0d, actual %0d", want.size, out_if.frame_len);
          fail_count++;
        end
        if (out_if.fingerprint !== want.fp) begin
          $error("fingerprint: expected %h, actual %h", want.fp, out_if.fingerprint);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("timeout: no item moved for %0d cycles", idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.frame_byte = '0;
    in_if.last_byte  = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CfgEnable;
    cfg_if.data      = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_disabled_after_reset();
    test_first_frame();
    test_thresholds();
    test_stride_extremes();
    test_mid_frame_changes();
    test_output_stall();
    test_random_frames();

    in_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d frame results (%0d changed) from %0d bytes and %0d register writes,",
             verdicts_checked, changes_seen, bytes_sent, cfg_writes);
    $display("covering stride/threshold extremes, mid-frame changes and output stalls.");
    if (fail_count == 0 && pending_verdicts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: frame_change_detector_top.f
rtl/core/fcd_pkg.sv
rtl/core/fcd_in_if.sv
rtl/core/fcd_out_if.sv
rtl/core/fcd_cfg_if.sv
rtl/core/fcd_accum.sv
rtl/core/fcd_judge.sv
rtl/core/frame_change_detector_top.sv
tb/testbench.sv
